[design/urtb_pkg.sv]
// ----------------------------------------------------------------------------
// UART ring buffer package
// Shared sizes, codes and controller/datapath interface types for the
// receive ring and transmit block buffer.
// ----------------------------------------------------------------------------
package urtb_pkg;

    // Store depths.
    localparam int RX_DEPTH = 8;
    localparam int TX_DEPTH = 32;

    // Address widths of the stores, and the width of the transmit counters,
    // which must also hold the depth itself.
    localparam int RX_AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int TX_AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
    localparam int TX_CW = $clog2(TX_DEPTH + 1);

    // Last receive position before the ring wraps, and the full transmit count.
    localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);
    localparam logic [TX_CW-1:0] TX_FULL = TX_CW'(TX_DEPTH);

    // Field widths.
    localparam int KIND_W   = 3;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;

    // Request kinds. Codes five to seven have no effect.
    typedef enum logic [KIND_W-1:0] {
        KIND_RX_BYTE  = 3'd0,
        KIND_HOST_RD  = 3'd1,
        KIND_TX_LOAD  = 3'd2,
        KIND_TX_READY = 3'd3,
        KIND_CLEAR    = 3'd4
    } t_kind;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 3'd0,
        ST_BYTE_RD  = 3'd1,
        ST_NO_DATA  = 3'd2,
        ST_RX_OVF   = 3'd3,
        ST_BUSY     = 3'd4,
        ST_INVALID  = 3'd5,
        ST_SENT     = 3'd6,
        ST_TX_IDLE  = 3'd7
    } t_status;

    // Controller states.
    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // latch the request being accepted
        logic commit;   // apply the latched request and load the result
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free; // result register can take a new result this cycle
    } t_dp_stat;

endpackage

[design/urtb_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module urtb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/urtb_ctrl.sv]
// ----------------------------------------------------------------------------
// UART ring buffer controller
// Sequences each request: accept, then apply it once the result register
// is free.
// ----------------------------------------------------------------------------
module urtb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  urtb_pkg::t_dp_stat i_stat,
    output urtb_pkg::t_cmd    o_cmd
);

    urtb_pkg::t_state r_state;
    urtb_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= urtb_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state       = r_state;
        o_in_ready    = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.commit  = 1'b0;
        case (r_state)
            urtb_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = urtb_pkg::S_EXEC;
                end
            end
            urtb_pkg::S_EXEC: begin
                // The store read issued at acceptance is ready now; wait only
                // for room in the result register.
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = urtb_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = urtb_pkg::S_IDLE;
            end
        endcase
    end

endmodule

[design/urtb_dp.sv]
// ----------------------------------------------------------------------------
// UART ring buffer datapath
// Request latch, receive ring and transmit block state, both stores and
// the result register.
// ----------------------------------------------------------------------------
module urtb_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  urtb_pkg::t_cmd               i_cmd,
    output urtb_pkg::t_dp_stat           o_stat,
    input  logic [urtb_pkg::KIND_W-1:0]  i_kind,
    input  logic [urtb_pkg::BYTE_W-1:0]  i_byte,
    input  logic                         i_last,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [urtb_pkg::STATUS_W-1:0] o_status,
    output logic [urtb_pkg::BYTE_W-1:0]  o_byte,
    output logic                         o_sending
);

    // Latched request.
    logic [urtb_pkg::KIND_W-1:0] r_kind;
    logic [urtb_pkg::BYTE_W-1:0] r_byte;
    logic                        r_last;

    // Receive ring state.
    logic [urtb_pkg::RX_AW-1:0] r_take_pos, n_take_pos;
    logic [urtb_pkg::RX_AW-1:0] r_put_pos, n_put_pos;
    logic                       r_rx_ovf, n_rx_ovf;

    // Transmit block state.
    logic [urtb_pkg::TX_CW-1:0] r_send_pos, n_send_pos;
    logic [urtb_pkg::TX_CW-1:0] r_block_len, n_block_len;
    logic                       r_tx_running, n_tx_running;
    logic [urtb_pkg::TX_CW-1:0] r_load_count, n_load_count;
    logic                       r_load_busy, n_load_busy;
    logic                       r_load_long, n_load_long;

    // Result register.
    logic                          r_out_valid;
    logic [urtb_pkg::STATUS_W-1:0] r_out_status, n_out_status;
    logic [urtb_pkg::BYTE_W-1:0]   r_out_byte, n_out_byte;
    logic                          r_out_sending;

    // Store ports.
    logic                        rx_we;
    logic [urtb_pkg::BYTE_W-1:0] rx_rdata;
    logic                        tx_we;
    logic [urtb_pkg::BYTE_W-1:0] tx_rdata;

    // Helpers for the load step.
    logic busy_eff;
    logic long_eff;

    assign o_stat.out_free = !r_out_valid || i_out_ready;

    // Receive store, read at the take position.
    urtb_ram #(
        .WIDTH (urtb_pkg::BYTE_W),
        .DEPTH (urtb_pkg::RX_DEPTH)
    ) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_waddr (r_put_pos),
        .i_wdata (r_byte),
        .i_raddr (r_take_pos),
        .o_rdata (rx_rdata)
    );

    // Transmit store, written at the load count and read at the send position.
    urtb_ram #(
        .WIDTH (urtb_pkg::BYTE_W),
        .DEPTH (urtb_pkg::TX_DEPTH)
    ) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_waddr (r_load_count[urtb_pkg::TX_AW-1:0]),
        .i_wdata (r_byte),
        .i_raddr (r_send_pos[urtb_pkg::TX_AW-1:0]),
        .o_rdata (tx_rdata)
    );

    // Request decode and next state.
    always_comb begin
        n_take_pos   = r_take_pos;
        n_put_pos    = r_put_pos;
        n_rx_ovf     = r_rx_ovf;
        n_send_pos   = r_send_pos;
        n_block_len  = r_block_len;
        n_tx_running = r_tx_running;
        n_load_count = r_load_count;
        n_load_busy  = r_load_busy;
        n_load_long  = r_load_long;
        n_out_status = urtb_pkg::ST_DONE;
        n_out_byte   = '0;
        rx_we        = 1'b0;
        tx_we        = 1'b0;
        busy_eff     = r_load_busy;
        long_eff     = r_load_long;
        case (urtb_pkg::t_kind'(r_kind))
            urtb_pkg::KIND_RX_BYTE: begin
                rx_we     = i_cmd.commit;
                n_put_pos = (r_put_pos == urtb_pkg::RX_LAST) ? '0 : r_put_pos + 1'b1;
                if (n_put_pos == r_take_pos) begin
                    n_rx_ovf = 1'b1;
                end
            end
            urtb_pkg::KIND_HOST_RD: begin
                if (r_rx_ovf) begin
                    n_out_status = urtb_pkg::ST_RX_OVF;
                end else if (r_take_pos == r_put_pos) begin
                    n_out_status = urtb_pkg::ST_NO_DATA;
                end else begin
                    n_out_status = urtb_pkg::ST_BYTE_RD;
                    n_out_byte   = rx_rdata;
                    n_take_pos   = (r_take_pos == urtb_pkg::RX_LAST) ? '0
                                                                    : r_take_pos + 1'b1;
                end
            end
            urtb_pkg::KIND_TX_LOAD: begin
                // The first byte of a block samples whether a transmission runs.
                if (r_load_count == '0) begin
                    busy_eff = r_tx_running;
                    long_eff = 1'b0;
                end
                if (r_load_count < urtb_pkg::TX_FULL) begin
                    tx_we        = i_cmd.commit && !busy_eff;
                    n_load_count = r_load_count + 1'b1;
                end else begin
                    long_eff = 1'b1;
                end
                n_load_busy = busy_eff;
                n_load_long = long_eff;
                if (r_last) begin
                    if (busy_eff) begin
                        n_out_status = urtb_pkg::ST_BUSY;
                    end else if (long_eff) begin
                        n_out_status = urtb_pkg::ST_INVALID;
                    end else begin
                        n_block_len  = n_load_count;
                        n_send_pos   = '0;
                        n_tx_running = 1'b1;
                    end
                    n_load_count = '0;
                    n_load_busy  = 1'b0;
                    n_load_long  = 1'b0;
                end
            end
            urtb_pkg::KIND_TX_READY: begin
                if (r_tx_running) begin
                    n_out_status = urtb_pkg::ST_SENT;
                    n_out_byte   = tx_rdata;
                    n_send_pos   = r_send_pos + 1'b1;
                    if (n_send_pos >= r_block_len) begin
                        n_tx_running = 1'b0;
                    end
                end else begin
                    n_out_status = urtb_pkg::ST_TX_IDLE;
                end
            end
            urtb_pkg::KIND_CLEAR: begin
                n_take_pos   = '0;
                n_put_pos    = '0;
                n_rx_ovf     = 1'b0;
                n_send_pos   = '0;
                n_block_len  = '0;
                n_tx_running = 1'b0;
                n_load_count = '0;
                n_load_busy  = 1'b0;
                n_load_long  = 1'b0;
            end
            default: begin
                n_out_status = urtb_pkg::ST_DONE;
            end
        endcase
    end

    // Request latch; payload only.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind <= i_kind;
            r_byte <= i_byte;
            r_last <= i_last;
        end
    end

    // Buffer state, updated when a request is applied.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_take_pos   <= '0;
            r_put_pos    <= '0;
            r_rx_ovf     <= 1'b0;
            r_send_pos   <= '0;
            r_block_len  <= '0;
            r_tx_running <= 1'b0;
            r_load_count <= '0;
            r_load_busy  <= 1'b0;
            r_load_long  <= 1'b0;
        end else if (i_cmd.commit) begin
            r_take_pos   <= n_take_pos;
            r_put_pos    <= n_put_pos;
            r_rx_ovf     <= n_rx_ovf;
            r_send_pos   <= n_send_pos;
            r_block_len  <= n_block_len;
            r_tx_running <= n_tx_running;
            r_load_count <= n_load_count;
            r_load_busy  <= n_load_busy;
            r_load_long  <= n_load_long;
        end
    end

    // Result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_status  <= n_out_status;
            r_out_byte    <= n_out_byte;
            r_out_sending <= n_tx_running;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_byte      = r_out_byte;
    assign o_sending   = r_out_sending;

    // The load counter never passes the store depth.
    a_load_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_load_count <= urtb_pkg::TX_FULL)
        else $error("Transmit load count exceeds the store depth.");

    // A running transmission always has bytes left inside a non-empty block.
    a_send_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tx_running |-> (r_send_pos < r_block_len && r_block_len <= urtb_pkg::TX_FULL))
        else $error("Send position outside the running block.");

    // A result is never loaded over one that has not been taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (!r_out_valid || i_out_ready))
        else $error("Result register overwritten while pending.");

    // A pending result holds until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_out_status)
                                           && $stable(r_out_byte)))
        else $error("Pending result changed before it was taken.");

endmodule

[design/uart_rx_ring_tx_block_buffer.sv]
// An accepted request is latched, then applied and loaded into the result register once
// that register is free; a result still waiting to be taken holds the next one back until it leaves.
// A new request is taken only after the last one has been applied; the registered read of
// the ring or transmit store completes between acceptance and result.
// Reset (synchronous, active low) clears positions, flags and counters;
// store contents stay undefined until written.
// ----------------------------------------------------------------------------
// UART receive ring and transmit block buffer
// Buffers received bytes for a host and sends loaded blocks byte by byte.
// ----------------------------------------------------------------------------
module uart_rx_ring_tx_block_buffer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
    input  logic [2:0]  s_axis_tuser,   // [2:0] kind
    input  logic        s_axis_tlast,   // block_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] byte_out, [8] sending, [15:9] zero
    output logic [2:0]  m_axis_tuser    // [2:0] status
);

    urtb_pkg::t_cmd     cmd;
    urtb_pkg::t_dp_stat stat;
    logic [urtb_pkg::BYTE_W-1:0] out_byte;
    logic                        out_sending;

    // Request sequencing.
    urtb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Buffers and result register.
    urtb_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_kind      (s_axis_tuser),
        .i_byte      (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_status    (m_axis_tuser),
        .o_byte      (out_byte),
        .o_sending   (out_sending)
    );

    assign m_axis_tdata = {7'd0, out_sending, out_byte};

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART ring buffer testbench
// Streams receive, host read, transmit load, transmitter ready and clear
// requests into the buffer with random gaps on both sides. Every result is
// checked field by field against a cycle-free model of the two stores.
// ----------------------------------------------------------------------------
module tb;

    // Kind codes that the block ignores.
    localparam logic [urtb_pkg::KIND_W-1:0] KIND_SPARE_LO = 3'd5;
    localparam logic [urtb_pkg::KIND_W-1:0] KIND_SPARE_HI = 3'd7;

    localparam int RANDOM_ITEMS  = 800;
    localparam int MAX_GAP       = 18;
    localparam int PRESSURE_AT   = 250;
    localparam int PRESSURE_HOLD = 400;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int ROW_COUNT     = 26;

    // One result of the block.
    typedef struct packed {
        urtb_pkg::t_status           status;
        logic [urtb_pkg::BYTE_W-1:0] byte_out;
        logic                        sending;
    } t_result;

    // One request, with an optional hand-written expectation.
    typedef struct packed {
        logic [urtb_pkg::KIND_W-1:0] kind;
        logic [urtb_pkg::BYTE_W-1:0] byte_in;
        logic                        block_end;
        logic                        typed;
        urtb_pkg::t_status           status;
        logic [urtb_pkg::BYTE_W-1:0] byte_out;
        logic                        sending;
    } t_plan_row;

    // Directed requests. Rows with typed set carry their own expectation.
    localparam t_plan_row DIRECTED_ROWS [0:ROW_COUNT-1] = '{
        '{urtb_pkg::KIND_HOST_RD,  8'h00, 1'b0, 1'b1, urtb_pkg::ST_NO_DATA, 8'h00, 1'b0},
        '{urtb_pkg::KIND_TX_READY, 8'hFF, 1'b1, 1'b1, urtb_pkg::ST_TX_IDLE, 8'h00, 1'b0},
        '{urtb_pkg::KIND_RX_BYTE,  8'h00, 1'b0, 1'b1, urtb_pkg::ST_DONE,    8'h00, 1'b0},
        '{urtb_pkg::KIND_RX_BYTE,  8'hFF, 1'b1, 1'b1, urtb_pkg::ST_DONE,    8'h00, 1'b0},
        '{urtb_pkg::KIND_HOST_RD,  8'h00, 1'b0, 1'b1, urtb_pkg::ST_BYTE_RD, 8'h00, 1'b0},
        '{urtb_pkg::KIND_HOST_RD,  8'h00, 1'b0, 1'b1, urtb_pkg::ST_BYTE_RD, 8'hFF, 1'b0},
        // Eight writes bring the write position round onto the read one.
        '{urtb_pkg::KIND_RX_BYTE,  8'h81, 1'b0, 1'b1, urtb_pkg::ST_DONE,    8'h00, 1'b0},
        '{urtb_pkg::KIND_RX_BYTE,  8'h42, 1'b0, 1'b1, urtb_pkg::ST_DONE,    8'h00, 1'b0},
        '{urtb_pkg::KIND_RX_BYTE,  8'h24, 1'b0, 1'b1, urtb_pkg::ST_DONE,    8'h00, 1'b0},
        '{urtb_pkg::KIND_RX_BYTE,  8'h18, 1'b0, 1'b1, urtb_pkg::ST_DONE,    8'h00, 1'b0},
        '{urtb_pkg::KIND_RX_BYTE,  8'hA5, 1'b0, 1'b1, urtb_pkg::ST_DONE,    8'h00, 1'b0},
        '{urtb_pkg::KIND_RX_BYTE,  8'h5A, 1'b0, 1'b1, urtb_pkg::ST_DONE,    8'h00, 1'b0},
        '{urtb_pkg::KIND_RX_BYTE,  8'h3C, 1'b0, 1'b1, urtb_pkg::ST_DONE,    8'h00, 1'b0},
        '{urtb_pkg::KIND_RX_BYTE,  8'hC3, 1'b0, 1'b1, urtb_pkg::ST_DONE,    8'h00, 1'b0},
        // A write while overflowed still lands, and reads report overflow.
        '{urtb_pkg::KIND_RX_BYTE,  8'h99, 1'b0, 1'b0, urtb_pkg::ST_DONE,    8'h00, 1'b0},
        '{urtb_pkg::KIND_HOST_RD,  8'h00, 1'b0, 1'b1, urtb_pkg::ST_RX_OVF,  8'h00, 1'b0},
        '{urtb_pkg::KIND_CLEAR,    8'h00, 1'b0, 1'b1, urtb_pkg::ST_DONE,    8'h00, 1'b0},
        // A two-byte block, then a block offered while it is being sent.
        '{urtb_pkg::KIND_TX_LOAD,  8'h5A, 1'b0, 1'b0, urtb_pkg::ST_DONE,    8'h00, 1'b0},
        '{urtb_pkg::KIND_TX_LOAD,  8'hC3, 1'b1, 1'b0, urtb_pkg::ST_DONE,    8'h00, 1'b0},
        '{urtb_pkg::KIND_TX_LOAD,  8'h11, 1'b1, 1'b1, urtb_pkg::ST_BUSY,    8'h00, 1'b1},
        '{urtb_pkg::KIND_TX_READY, 8'h00, 1'b0, 1'b0, urtb_pkg::ST_DONE,    8'h00, 1'b0},
        '{urtb_pkg::KIND_TX_READY, 8'h00, 1'b0, 1'b0, urtb_pkg::ST_DONE,    8'h00, 1'b0},
        // Clear in the middle of a transmission stops it.
        '{urtb_pkg::KIND_TX_LOAD,  8'hE7, 1'b1, 1'b0, urtb_pkg::ST_DONE,    8'h00, 1'b0},
        '{urtb_pkg::KIND_CLEAR,    8'hFF, 1'b1, 1'b1, urtb_pkg::ST_DONE,    8'h00, 1'b0},
        '{KIND_SPARE_LO,           8'hFF, 1'b1, 1'b1, urtb_pkg::ST_DONE,    8'h00, 1'b0},
        '{KIND_SPARE_HI,           8'h00, 1'b0, 1'b1, urtb_pkg::ST_DONE,    8'h00, 1'b0}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] byte_in
    logic [2:0]  s_axis_tuser;   // [2:0] kind
    logic        s_axis_tlast;   // block_end
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [7:0] byte_out, [8] sending, [15:9] zero
    logic [2:0]  m_axis_tuser;   // [2:0] status

    t_plan_row request_plan [$];
    t_result   pending_results [$];
    t_plan_row offered;
    int        mismatches = 0;
    int        quiet_cycles = 0;

    // Model of the stores, positions and load tracking.
    logic [urtb_pkg::BYTE_W-1:0] rx_ring [urtb_pkg::RX_DEPTH];
    logic [urtb_pkg::RX_AW-1:0]  rx_rd_pos, rx_wr_pos;
    logic                        rx_ovf;
    logic [urtb_pkg::BYTE_W-1:0] tx_mem [urtb_pkg::TX_DEPTH];
    logic [urtb_pkg::TX_CW-1:0]  tx_pos, tx_len, load_cnt;
    logic                        tx_active, load_busy, load_long;

    uart_rx_ring_tx_block_buffer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 i_clk = ~i_clk;

    // Positions, flags and counters go back to zero; store contents stay.
    function void clear_buffer_model();
        rx_rd_pos = '0;
        rx_wr_pos = '0;
        rx_ovf    = 1'b0;
        tx_pos    = '0;
        tx_len    = '0;
        tx_active = 1'b0;
        load_cnt  = '0;
        load_busy = 1'b0;
        load_long = 1'b0;
    endfunction

    // Applies one request to the model and returns the result it causes.
    function automatic t_result predict_buffer_result(logic [urtb_pkg::KIND_W-1:0] kind,
                                                      logic [urtb_pkg::BYTE_W-1:0] data,
                                                      logic last);
        t_result r;
        r = '{status: urtb_pkg::ST_DONE, byte_out: 8'h00, sending: 1'b0};
        case (kind)
            urtb_pkg::KIND_RX_BYTE: begin
                // Written even while overflowed; the flag is sticky.
                rx_ring[rx_wr_pos] = data;
                rx_wr_pos = (rx_wr_pos == urtb_pkg::RX_LAST) ? '0 : rx_wr_pos + 1'b1;
                if (rx_wr_pos == rx_rd_pos) rx_ovf = 1'b1;
            end
            urtb_pkg::KIND_HOST_RD: begin
                if (rx_ovf) begin
                    r.status = urtb_pkg::ST_RX_OVF;
                end else if (rx_rd_pos == rx_wr_pos) begin
                    r.status = urtb_pkg::ST_NO_DATA;
                end else begin
                    r.status   = urtb_pkg::ST_BYTE_RD;
                    r.byte_out = rx_ring[rx_rd_pos];
                    rx_rd_pos  = (rx_rd_pos == urtb_pkg::RX_LAST) ? '0 : rx_rd_pos + 1'b1;
                end
            end
            urtb_pkg::KIND_TX_LOAD: begin
                // The first byte decides whether the block collides with a send.
                if (load_cnt == '0) begin
                    load_busy = tx_active;
                    load_long = 1'b0;
                end
                if (load_cnt < urtb_pkg::TX_FULL) begin
                    if (!load_busy) tx_mem[load_cnt[urtb_pkg::TX_AW-1:0]] = data;
                    load_cnt = load_cnt + 1'b1;
                end else begin
                    load_long = 1'b1;
                end
                if (last) begin
                    if (load_busy) begin
                        r.status = urtb_pkg::ST_BUSY;
                    end else if (load_long) begin
                        r.status = urtb_pkg::ST_INVALID;
                    end else begin
                        tx_len    = load_cnt;
                        tx_pos    = '0;
                        tx_active = 1'b1;
                    end
                    load_cnt  = '0;
                    load_busy = 1'b0;
                    load_long = 1'b0;
                end
            end
            urtb_pkg::KIND_TX_READY: begin
                if (tx_active) begin
                    r.status   = urtb_pkg::ST_SENT;
                    r.byte_out = tx_mem[tx_pos[urtb_pkg::TX_AW-1:0]];
                    tx_pos     = tx_pos + 1'b1;
                    if (tx_pos >= tx_len) tx_active = 1'b0;
                end else begin
                    r.status = urtb_pkg::ST_TX_IDLE;
                end
            end
            urtb_pkg::KIND_CLEAR: clear_buffer_model();
            default: ;
        endcase
        r.sending = tx_active;
        return r;
    endfunction

    function void queue_request(logic [urtb_pkg::KIND_W-1:0] kind,
                                logic [urtb_pkg::BYTE_W-1:0] data, logic last);
        t_plan_row row;
        row = '{kind, data, last, 1'b0, urtb_pkg::ST_DONE, 8'h00, 1'b0};
        request_plan.push_back(row);
    endfunction

    // Prediction at each accepted request, and checking of each taken result.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                want = predict_buffer_result(offered.kind, offered.byte_in,
                                             offered.block_end);
                if (offered.typed)
                    want = '{status: offered.status, byte_out: offered.byte_out,
                             sending: offered.sending};
                pending_results.push_back(want);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result, status %0d data %h",
                             $time, m_axis_tuser, m_axis_tdata);
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (m_axis_tuser !== want.status) begin
                        $display("%0t: status expected %0d, actual %0d",
                                 $time, want.status, m_axis_tuser);
                        mismatches++;
                    end
                    if (m_axis_tdata[7:0] !== want.byte_out) begin
                        $display("%0t: byte_out expected %h, actual %h",
                                 $time, want.byte_out, m_axis_tdata[7:0]);
                        mismatches++;
                    end
                    if (m_axis_tdata[8] !== want.sending) begin
                        $display("%0t: sending expected %b, actual %b",
                                 $time, want.sending, m_axis_tdata[8]);
                        mismatches++;
                    end
                    if (m_axis_tdata[15:9] !== 7'd0) begin
                        $display("%0t: padding expected %h, actual %h",
                                 $time, 7'd0, m_axis_tdata[15:9]);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles in which neither side moves a request or result.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Result side: random hold-offs, calm stretches and one long stall.
    initial begin
        int  gap;
        bit  calm;
        int  taken;
        m_axis_tready = 1'b0;
        taken = 0;
        calm  = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (taken % 64 == 0) calm = ($urandom_range(0, 2) == 0);
            gap = calm ? 0 : $urandom_range(0, MAX_GAP);
            if (taken == PRESSURE_AT) gap = PRESSURE_HOLD;
            if (gap != 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            taken++;
        end
    end

    // Reset, stimulus and the final verdict.
    initial begin
        int gap;
        bit calm;
        int roll;
        int len;
        bit cut;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tuser  = urtb_pkg::KIND_RX_BYTE;
        s_axis_tlast  = 1'b0;
        offered       = '0;
        calm          = 1'b0;
        clear_buffer_model();

        for (int n = 0; n < ROW_COUNT; n++) request_plan.push_back(DIRECTED_ROWS[n]);

        // Random part: mostly coherent bursts and blocks, some noise.
        while (request_plan.size() < ROW_COUNT + RANDOM_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < 25) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 10)
                                                  : $urandom_range(1, 5);
                repeat (len) queue_request(urtb_pkg::KIND_RX_BYTE, 8'($urandom),
                                           1'($urandom));
            end else if (roll < 48) begin
                repeat ($urandom_range(1, 6))
                    queue_request(urtb_pkg::KIND_HOST_RD, 8'($urandom), 1'($urandom));
            end else if (roll < 72) begin
                // Mostly short blocks, now and then a full or oversized one.
                case ($urandom_range(0, 19))
                    0:       len = urtb_pkg::TX_DEPTH;
                    1:       len = $urandom_range(urtb_pkg::TX_DEPTH + 1,
                                                  urtb_pkg::TX_DEPTH + 4);
                    default: len = $urandom_range(1, 8);
                endcase
                cut = ($urandom_range(0, 11) == 0);
                for (int i = 1; i <= len; i++)
                    queue_request(urtb_pkg::KIND_TX_LOAD, 8'($urandom),
                                  (i == len) && !cut);
                if (cut) queue_request(urtb_pkg::KIND_CLEAR, 8'($urandom), 1'($urandom));
            end else if (roll < 90) begin
                repeat ($urandom_range(1, 6))
                    queue_request(urtb_pkg::KIND_TX_READY, 8'($urandom), 1'($urandom));
            end else if (roll < 95) begin
                queue_request(urtb_pkg::KIND_CLEAR, 8'($urandom), 1'($urandom));
            end else begin
                queue_request(3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)),
                              8'($urandom), 1'($urandom));
            end
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Offer each request, with a random gap before it.
        for (int n = 0; n < request_plan.size(); n++) begin
            if (n % 64 == 0) calm = ($urandom_range(0, 2) == 0);
            gap = calm ? 0 : $urandom_range(0, MAX_GAP);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            offered       <= request_plan[n];
            s_axis_tuser  <= request_plan[n].kind;
            s_axis_tdata  <= request_plan[n].byte_in;
            s_axis_tlast  <= request_plan[n].block_end;
            s_axis_tvalid <= 1'b1;
            @(posedge i_clk);
            while (!s_axis_tready) @(posedge i_clk);
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
